@@ rtl/stok_pkg.sv @@
// Shared types, token codes and character-class functions for the source tokenizer.
`default_nettype none
package stok_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LINE_BITS_DEF     = 16;
    localparam int QUEUE_DEPTH       = 4;

    // Token codes
    localparam logic [5:0] TK_LPAREN = 6'd0;
    localparam logic [5:0] TK_RPAREN = 6'd1;
    localparam logic [5:0] TK_LBRACE = 6'd2;
    localparam logic [5:0] TK_RBRACE = 6'd3;
    localparam logic [5:0] TK_LBRACK = 6'd4;
    localparam logic [5:0] TK_RBRACK = 6'd5;
    localparam logic [5:0] TK_SEMI   = 6'd6;
    localparam logic [5:0] TK_COMMA  = 6'd7;
    localparam logic [5:0] TK_DOT    = 6'd8;
    localparam logic [5:0] TK_MINUS  = 6'd9;
    localparam logic [5:0] TK_PLUS   = 6'd10;
    localparam logic [5:0] TK_SLASH  = 6'd11;
    localparam logic [5:0] TK_STAR   = 6'd12;
    localparam logic [5:0] TK_BANG   = 6'd13;
    localparam logic [5:0] TK_EQ     = 6'd15;
    localparam logic [5:0] TK_LT     = 6'd17;
    localparam logic [5:0] TK_GT     = 6'd19;
    localparam logic [5:0] TK_IDENT  = 6'd21;
    localparam logic [5:0] TK_STRING = 6'd22;
    localparam logic [5:0] TK_NUMBER = 6'd23;
    localparam logic [5:0] TK_KW0    = 6'd24;
    localparam logic [5:0] TK_ERROR  = 6'd43;
    localparam logic [5:0] TK_END    = 6'd44;

    // Error kinds
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_CHAR   = 2'd1;
    localparam logic [1:0] ERR_UNTERM = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;

    // Keywords, first byte in the top byte, zero padded
    localparam logic [47:0] KW_TEXT [19] = '{
        {"and", 24'h0}, {"class", 8'h0}, {"else", 16'h0}, {"false", 8'h0},
        {"for", 24'h0}, {"fn", 32'h0}, {"if", 32'h0}, {"in", 32'h0},
        {"match", 8'h0}, {"null", 16'h0}, {"or", 32'h0}, {"print", 8'h0},
        "return", {"super", 8'h0}, {"this", 16'h0}, {"true", 16'h0},
        {"type", 16'h0}, {"var", 24'h0}, {"while", 8'h0}
    };
    localparam logic [2:0] KW_LEN [19] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd2, 3'd2, 3'd2, 3'd5, 3'd4,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5
    };

    typedef struct packed {
        logic [5:0]  ttype;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic [1:0]  err;
    } t_token;

    typedef struct packed {
        logic [1:0]     cnt;
        t_token [2:0]   tok;
    } t_bundle;

    typedef struct packed {
        logic    push;
        t_bundle data;
    } t_push;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Single-character punctuation; bit 6 flags a match
    function automatic logic [6:0] single_type(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        case (c)
            "(": r = {1'b1, TK_LPAREN};
            ")": r = {1'b1, TK_RPAREN};
            "{": r = {1'b1, TK_LBRACE};
            "}": r = {1'b1, TK_RBRACE};
            "[": r = {1'b1, TK_LBRACK};
            "]": r = {1'b1, TK_RBRACK};
            ";": r = {1'b1, TK_SEMI};
            ",": r = {1'b1, TK_COMMA};
            ".": r = {1'b1, TK_DOT};
            "-": r = {1'b1, TK_MINUS};
            "+": r = {1'b1, TK_PLUS};
            "*": r = {1'b1, TK_STAR};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // First character of a two-character operator; bit 6 flags a match
    function automatic logic [6:0] op_base(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        case (c)
            "!": r = {1'b1, TK_BANG};
            "=": r = {1'b1, TK_EQ};
            "<": r = {1'b1, TK_LT};
            ">": r = {1'b1, TK_GT};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] word_type(input logic [47:0] b, input logic [2:0] len);
        logic [5:0] r;
        r = TK_IDENT;
        for (int i = 0; i < 19; i++) begin
            if (len == KW_LEN[i] && b == KW_TEXT[i]) begin
                r = TK_KW0 + 6'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/stok_front.sv @@
// Front end: accepts source bytes, runs the scanner and forms token bundles.
`default_nettype none
module stok_front #(
    parameter int PB = stok_pkg::POSITION_BITS_DEF,
    parameter int LB = stok_pkg::LINE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_ch,
    input  wire logic           i_full,
    output stok_pkg::t_push     o_push
);

    typedef enum logic [3:0] {
        S_IDLE, S_SLASH, S_COMMENT, S_IDENT, S_NUMBER, S_NUMDOT, S_FRACTION, S_STRING, S_OP2
    } t_mode;

    localparam logic [PB-1:0] POS_MAX  = {PB{1'b1}};
    localparam logic [LB-1:0] LINE_MAX = {LB{1'b1}};

    t_mode          r_mode, n_mode;
    logic [PB-1:0]  r_start, n_start;
    logic [PB-1:0]  r_pos, n_pos;
    logic [LB-1:0]  r_line, n_line;
    logic [47:0]    r_wbuf, n_wbuf;
    logic [2:0]     r_wlen, n_wlen;
    logic [7:0]     r_pend, n_pend;

    stok_pkg::t_token [2:0] tk;
    logic [1:0]     ntok;
    logic           acc;

    function automatic logic [PB-1:0] span(input logic [PB-1:0] hi, input logic [PB-1:0] lo);
        return (hi > lo) ? hi - lo : '0;
    endfunction

    function automatic stok_pkg::t_token mk(input logic [5:0] ty, input logic [PB-1:0] st,
                                            input logic [PB-1:0] ln, input logic [1:0] ek,
                                            input logic [LB-1:0] lc);
        stok_pkg::t_token t;
        logic [PB+15:0] sx;
        logic [PB+15:0] lx;
        logic [LB+15:0] cx;
        sx = {16'b0, st};
        lx = {16'b0, ln};
        cx = {16'b0, lc};
        t.ttype  = ty;
        t.start  = sx[15:0];
        t.length = lx[15:0];
        t.line   = cx[15:0];
        t.err    = ek;
        return t;
    endfunction

    assign acc = i_valid & ~i_full;

    // Scan one byte: extend or close the open token, then start on the byte if it is free
    always_comb begin
        logic          beg;
        logic [PB-1:0] p;
        logic [PB-1:0] so;
        logic [PB-1:0] s;
        logic [PB-1:0] dot;
        logic [6:0]    st;
        logic [6:0]    ob;
        logic [5:0]    base;
        beg     = 1'b0;
        p       = r_pos;
        so      = r_start;
        s       = span(p, so);
        dot     = '0;
        st      = stok_pkg::single_type(i_ch);
        ob      = stok_pkg::op_base(r_pend);
        base    = ob[6] ? ob[5:0] : stok_pkg::TK_BANG;
        n_mode  = r_mode;
        n_start = r_start;
        n_line  = r_line;
        n_wbuf  = r_wbuf;
        n_wlen  = r_wlen;
        n_pend  = r_pend;
        tk      = '0;
        ntok    = 2'd0;

        case (r_mode)
            S_SLASH: begin
                if (i_ch == stok_pkg::CH_SLASH) begin
                    n_mode = S_COMMENT;
                end else begin
                    tk[ntok] = mk(stok_pkg::TK_SLASH, so, PB'(1), stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                    beg = 1'b1;
                end
            end
            S_COMMENT: begin
                if (i_ch == stok_pkg::CH_LF || i_ch == stok_pkg::CH_NUL) beg = 1'b1;
            end
            S_IDENT: begin
                if (stok_pkg::is_alpha(i_ch) || stok_pkg::is_numeral(i_ch)) begin
                    if (r_wlen < 3'd6) n_wbuf[47 - 8 * r_wlen -: 8] = i_ch;
                    if (r_wlen < 3'd7) n_wlen = r_wlen + 3'd1;
                end else begin
                    tk[ntok] = mk(stok_pkg::word_type(r_wbuf, r_wlen), so, s,
                                  stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                    beg = 1'b1;
                end
            end
            S_NUMBER, S_FRACTION: begin
                if (stok_pkg::is_numeral(i_ch)) begin
                    n_mode = r_mode;
                end else if (i_ch == stok_pkg::CH_DOT && r_mode == S_NUMBER) begin
                    n_mode = S_NUMDOT;
                end else begin
                    tk[ntok] = mk(stok_pkg::TK_NUMBER, so, s, stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                    beg = 1'b1;
                end
            end
            S_NUMDOT: begin
                if (stok_pkg::is_numeral(i_ch)) begin
                    n_mode = S_FRACTION;
                end else begin
                    dot = (p > '0) ? p - PB'(1) : '0;
                    if (dot < so) dot = so;
                    tk[ntok] = mk(stok_pkg::TK_NUMBER, so, span(dot, so),
                                  stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                    tk[ntok] = mk(stok_pkg::TK_DOT, dot, PB'(1), stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                    beg = 1'b1;
                end
            end
            S_STRING: begin
                if (i_ch == stok_pkg::CH_QUOTE) begin
                    tk[ntok] = mk(stok_pkg::TK_STRING, so, (s == POS_MAX) ? s : s + PB'(1),
                                  stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                    n_mode = S_IDLE;
                end else if (i_ch == stok_pkg::CH_NUL) begin
                    tk[ntok] = mk(stok_pkg::TK_ERROR, so, s, stok_pkg::ERR_UNTERM, r_line);
                    ntok = ntok + 2'd1;
                    beg = 1'b1;
                end else if (i_ch == stok_pkg::CH_LF) begin
                    if (r_line < LINE_MAX) n_line = r_line + LB'(1);
                end
            end
            S_OP2: begin
                if (i_ch == stok_pkg::CH_EQUAL) begin
                    tk[ntok] = mk(base + 6'd1, so, (s == POS_MAX) ? s : s + PB'(1),
                                  stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                    n_mode = S_IDLE;
                end else begin
                    tk[ntok] = mk(base, so, PB'(1), stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                    beg = 1'b1;
                end
            end
            default: beg = 1'b1;
        endcase

        // Start on the current byte
        if (beg) begin
            n_mode = S_IDLE;
            if (i_ch == stok_pkg::CH_NUL) begin
                tk[ntok] = mk(stok_pkg::TK_END, p, '0, stok_pkg::ERR_NONE, r_line);
                ntok = ntok + 2'd1;
            end else if (i_ch == stok_pkg::CH_SPACE || i_ch == stok_pkg::CH_TAB ||
                         i_ch == stok_pkg::CH_CR) begin
                n_mode = S_IDLE;
            end else if (i_ch == stok_pkg::CH_LF) begin
                if (r_line < LINE_MAX) n_line = r_line + LB'(1);
            end else begin
                n_start = p;
                if (i_ch == stok_pkg::CH_SLASH) begin
                    n_mode = S_SLASH;
                end else if (stok_pkg::is_alpha(i_ch)) begin
                    n_wbuf = {i_ch, 40'h0};
                    n_wlen = 3'd1;
                    n_mode = S_IDENT;
                end else if (stok_pkg::is_numeral(i_ch)) begin
                    n_mode = S_NUMBER;
                end else if (i_ch == stok_pkg::CH_QUOTE) begin
                    n_mode = S_STRING;
                end else if (st[6]) begin
                    tk[ntok] = mk(st[5:0], p, PB'(1), stok_pkg::ERR_NONE, r_line);
                    ntok = ntok + 2'd1;
                end else if (stok_pkg::op_base(i_ch) != 7'd0) begin
                    n_pend = i_ch;
                    n_mode = S_OP2;
                end else begin
                    tk[ntok] = mk(stok_pkg::TK_ERROR, p, PB'(1), stok_pkg::ERR_CHAR, r_line);
                    ntok = ntok + 2'd1;
                end
            end
        end

        // Advance position; end of source restarts the count
        if (i_ch == stok_pkg::CH_NUL) begin
            n_pos  = '0;
            n_line = LB'(1);
            n_mode = S_IDLE;
        end else begin
            n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + PB'(1);
        end
    end

    assign o_push.push     = acc & (ntok != 2'd0);
    assign o_push.data.cnt = ntok;
    assign o_push.data.tok = tk;

    // Hold scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= S_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= LB'(1);
            r_wbuf  <= '0;
            r_wlen  <= 3'd0;
            r_pend  <= 8'd0;
        end else if (acc) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_wbuf  <= n_wbuf;
            r_wlen  <= n_wlen;
            r_pend  <= n_pend;
        end
    end

endmodule
`default_nettype wire

@@ rtl/stok_back.sv @@
// Back end: bundle queue and one-token-per-request output stage.
`default_nettype none
module stok_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire stok_pkg::t_push   i_push,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output stok_pkg::t_token       o_tok,
    output logic                   o_last
);

    localparam int AW = $clog2(stok_pkg::QUEUE_DEPTH);

    stok_pkg::t_bundle r_mem [stok_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic [1:0]        r_idx;
    logic              out_acc;
    logic              pop;
    logic              push;
    stok_pkg::t_bundle head;

    assign head    = r_mem[r_rp];
    assign o_full  = (r_cnt == (AW + 1)'(stok_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = head.tok[r_idx];
    assign o_last  = (r_idx == head.cnt - 2'd1);
    assign out_acc = o_valid & ~i_stall;
    assign pop     = out_acc & o_last;
    assign push    = i_push.push & ~o_full;

    // Store bundles
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_push.data;
    end

    // Advance pointers and the token index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_idx <= 2'd0;
        end else begin
            if (push) r_wp <= r_wp + AW'(1);
            if (pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW + 1)'(push) - (AW + 1)'(pop);
            if (pop) r_idx <= 2'd0;
            else if (out_acc) r_idx <= r_idx + 2'd1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW + 1)'(stok_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < head.cnt))
        else $error("token index beyond bundle");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !o_full)
        else $error("bundle pushed into full queue");
    a_empty_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> (i_push.data.cnt != 2'd0))
        else $error("empty bundle pushed");

endmodule
`default_nettype wire

@@ rtl/source_tokenizer.sv @@
// Top level of the source tokenizer: scanner front end and token queue back end.
//
//  channel  dir  handshake          payload
//  input    in   i_valid / o_stall  i_ch
//  output   out  o_valid / i_stall  o_tok_kind, o_token_start, o_token_length,
//                                   o_token_line, o_error_kind, o_last_of_run
//
// One byte is scanned per cycle while o_stall is low; its tokens enter a four-bundle
// queue at the accepting edge and are offered once earlier bundles have left it.
// Tokens leave one per cycle while i_stall is low, a byte's tokens one after another.
// The input stalls only while the bundle queue is full.
// Synchronous active-low reset returns to line 1, offset 0, idle scanning.
`default_nettype none
module source_tokenizer #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF,
    parameter int LINE_BITS     = stok_pkg::LINE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_tok_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic [15:0]      o_token_line,
    output logic [1:0]       o_error_kind,
    output logic             o_last_of_run
);

    stok_pkg::t_push  push;
    stok_pkg::t_token tok;
    logic             full;

    stok_front #(.PB(POSITION_BITS), .LB(LINE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ch    (i_ch),
        .i_full  (full),
        .o_push  (push)
    );

    stok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_tok   (tok),
        .o_last  (o_last_of_run)
    );

    assign o_stall        = full;
    assign o_tok_kind     = tok.ttype;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.length;
    assign o_token_line   = tok.line;
    assign o_error_kind   = tok.err;

endmodule
`default_nettype wire
